/* hw/rtl/pcs_pkg.sv */
// ----------------------------------------------------------------------------
// pcs_pkg: shared types and constants of the polynomial cosine/sine block
// Angle constants, Q60 Horner coefficients and the tag that travels with
// each item through the pipeline.
// ----------------------------------------------------------------------------
package pcs_pkg;

  localparam int ANGLE_FRAC_BITS  = 24;
  localparam int RESULT_FRAC_BITS = 30;

  // Working fraction of the polynomial datapath.
  localparam int WFRAC = 60;
  localparam int Z_W   = 62;
  localparam int ACC_W = 64;
  localparam int DEG_W = 3;

  localparam int NUM_STEPS = 6;

  localparam logic [DEG_W-1:0] DEG_MIN   = 3'd1;
  localparam logic [DEG_W-1:0] DEG_MAX   = 3'd6;
  localparam logic [DEG_W-1:0] DEG_RESET = 3'd6;

  // Pi with 62 fraction bits.
  localparam logic [63:0] PI_Q62 = 64'hC90FDAA22168C235;
  localparam logic [63:0] DEC19  = 64'd10000000000000000000;
  localparam logic [63:0] ONE_Q60 = 64'd1 << WFRAC;

  typedef struct packed {
    logic valid;
    logic flip;
  } pcs_tag_t;

  // Pi scaled by 2^e, rounded to nearest.
  function automatic logic [63:0] pi_scaled(int e);
    return (PI_Q62 + (64'd1 << (61 - e))) >> (62 - e);
  endfunction

  // Rounded num/den in Q60 for num < den, by restoring steps.
  function automatic logic [63:0] frac_q60(logic [63:0] num, logic [63:0] den);
    logic [63:0] r;
    logic [63:0] q;
    r = num;
    q = '0;
    for (int i = 0; i < WFRAC; i++) begin
      q = q << 1;
      if (r >= den - r) begin
        r = r - (den - r);
        q = q | 64'd1;
      end else begin
        r = r + r;
      end
    end
    if (r >= den - r) q = q + 64'd1;
    return q;
  endfunction

  // Number of shifted-modulus steps needed to reduce a 32-bit magnitude.
  function automatic int mod_steps(logic [63:0] modulus);
    int k;
    k = 0;
    for (int j = 0; j < 40; j++) begin
      if ((modulus << j) < 64'h1_0000_0000) k = j + 1;
    end
    return k;
  endfunction

  // Fitted top coefficients for degrees 2, 4, ... 12, indexed by order - 1.
  localparam logic [NUM_STEPS-1:0][63:0] FIT_Q60 = {
    frac_q60(64'd20596614152, DEC19),
    frac_q60(64'd2704911813978, DEC19),
    frac_q60(64'd241341770629924, DEC19),
    frac_q60(64'd13293401938494940, DEC19),
    frac_q60(64'd383866512097261799, DEC19),
    frac_q60(64'd4052847345693510858, DEC19)
  };

  // 1/(2k)! for k = 1..5, indexed by k - 1.
  localparam logic [NUM_STEPS-2:0][63:0] TAYLOR_Q60 = {
    frac_q60(64'd1, 64'd3628800),
    frac_q60(64'd1, 64'd40320),
    frac_q60(64'd1, 64'd720),
    frac_q60(64'd1, 64'd24),
    frac_q60(64'd1, 64'd2)
  };

  // Constant term of a Horner step; the closing step subtracts from one.
  function automatic logic [63:0] step_coef(int k);
    if (k == 0) return ONE_Q60;
    else return TAYLOR_Q60[k-1];
  endfunction

endpackage

/* hw/rtl/pcs_horner_step.sv */
// ----------------------------------------------------------------------------
// pcs_horner_step: one Horner step of the polynomial in z
// Four register stages: magnitude, 32x32 partial products, sum and round to
// Q60, then the add to the step constant. The closing step forms 1 - p with
// the region sign applied.
// ----------------------------------------------------------------------------
module pcs_horner_step #(
  parameter int STEP = 0
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           en,
  input  logic [pcs_pkg::DEG_W-1:0]      degree_i,
  input  pcs_pkg::pcs_tag_t              tag_i,
  input  logic [pcs_pkg::Z_W-1:0]        z_i,
  input  logic signed [pcs_pkg::ACC_W-1:0] acc_i,
  output pcs_pkg::pcs_tag_t              tag_o,
  output logic [pcs_pkg::Z_W-1:0]        z_o,
  output logic signed [pcs_pkg::ACC_W-1:0] acc_o
);

  localparam int ZW = pcs_pkg::Z_W;
  localparam int AW = pcs_pkg::ACC_W;
  localparam int WF = pcs_pkg::WFRAC;
  localparam bit LAST = (STEP == 0);
  localparam logic signed [AW-1:0] COEF = signed'(pcs_pkg::step_coef(STEP));
  localparam logic [127:0] ROUND_BIT = 128'd1 << (WF - 1);

  // Stage 1: magnitude of the accumulator.
  pcs_pkg::pcs_tag_t tag1_r;
  logic [AW-1:0]        ua_r, ua_nxt;
  logic                 neg1_r;
  logic [ZW-1:0]        z1_r;
  logic signed [AW-1:0] acc1_r;

  // Stage 2: partial products.
  pcs_pkg::pcs_tag_t tag2_r;
  logic [63:0]          p00_r, p01_r, p10_r, p11_r;
  logic [63:0]          p00_nxt, p01_nxt, p10_nxt, p11_nxt;
  logic                 neg2_r;
  logic [ZW-1:0]        z2_r;
  logic signed [AW-1:0] acc2_r;

  // Stage 3: rounded product magnitude.
  pcs_pkg::pcs_tag_t tag3_r;
  logic [127:0]         sum;
  logic [AW-1:0]        m_r, m_nxt;
  logic                 neg3_r;
  logic [ZW-1:0]        z3_r;
  logic signed [AW-1:0] acc3_r;

  // Stage 4: new accumulator.
  pcs_pkg::pcs_tag_t tag4_r;
  logic [ZW-1:0]        z4_r;
  logic signed [AW-1:0] acc4_r, acc4_nxt;
  logic signed [AW-1:0] base;
  logic signed [AW-1:0] m_s;
  logic signed [AW-1:0] total;
  logic                 add_pos;

  assign ua_nxt = acc_i[AW-1] ? unsigned'(-acc_i) : unsigned'(acc_i);

  assign p00_nxt = z1_r[31:0] * ua_r[31:0];
  assign p01_nxt = z1_r[31:0] * ua_r[63:32];
  assign p10_nxt = z1_r[ZW-1:32] * ua_r[31:0];
  assign p11_nxt = z1_r[ZW-1:32] * ua_r[63:32];

  assign sum = {64'd0, p00_r} + {32'd0, p01_r, 32'd0} + {32'd0, p10_r, 32'd0}
             + {p11_r, 64'd0} + ROUND_BIT;
  assign m_nxt = sum[WF+AW-1:WF];

  // z is never negative, so the product sign is the accumulator sign.
  always_comb begin
    m_s = signed'(m_r);
    if (LAST) begin
      base    = tag3_r.flip ? -COEF : COEF;
      add_pos = tag3_r.flip ^ neg3_r;
    end else begin
      base    = COEF;
      add_pos = neg3_r;
    end
    total = add_pos ? base + m_s : base - m_s;
    if (LAST || (pcs_pkg::DEG_W'(STEP) < degree_i)) begin
      acc4_nxt = total;
    end else begin
      acc4_nxt = acc3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tag1_r <= '0;
      tag2_r <= '0;
      tag3_r <= '0;
      tag4_r <= '0;
    end else if (en) begin
      tag1_r <= tag_i;
      tag2_r <= tag1_r;
      tag3_r <= tag2_r;
      tag4_r <= tag3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      ua_r   <= ua_nxt;
      neg1_r <= acc_i[AW-1];
      z1_r   <= z_i;
      acc1_r <= acc_i;

      p00_r  <= p00_nxt;
      p01_r  <= p01_nxt;
      p10_r  <= p10_nxt;
      p11_r  <= p11_nxt;
      neg2_r <= neg1_r;
      z2_r   <= z1_r;
      acc2_r <= acc1_r;

      m_r    <= m_nxt;
      neg3_r <= neg2_r;
      z3_r   <= z2_r;
      acc3_r <= acc2_r;

      z4_r   <= z3_r;
      acc4_r <= acc4_nxt;
    end
  end

  assign tag_o = tag4_r;
  assign z_o   = z4_r;
  assign acc_o = acc4_r;

endmodule

/* hw/rtl/poly_cosine_sine_approx.sv */
// ----------------------------------------------------------------------------
// poly_cosine_sine_approx: pipelined polynomial cosine and sine
// Range reduction, quadrant folding and a Horner polynomial of degree 2 to 12
// in the squared offset, Q8.24 angle in and Q2.30 result out.
// ----------------------------------------------------------------------------
// The block takes one angle per cycle while in_stall is low and returns one
// result per angle, in order. Registers form the argument and fold its
// sign, MOD_STEPS compare-subtract stages reduce it modulo 2pi, three
// stages fold it and square it, six Horner steps of four stages each share
// the work of the 64x64 products as 32x32 partial products, and two stages
// round and saturate. A one-entry skid buffer sits behind the output
// register, so an angle is still taken in the cycle that a result first
// stalls; in_stall rises once that entry is full. The user must see that
// degree_select is written only while no item is in flight;
// the block itself does not enforce this.
module poly_cosine_sine_approx #(
  parameter int ANGLE_FRAC_BITS  = pcs_pkg::ANGLE_FRAC_BITS,
  parameter int RESULT_FRAC_BITS = pcs_pkg::RESULT_FRAC_BITS
) (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_stall,
  input  logic                      in_operation,
  input  logic signed [31:0]        in_angle,
  output logic                      out_valid,
  input  logic                      out_stall,
  output logic signed [31:0]        out_value,
  input  logic                      cfg_valid,
  output logic                      cfg_ready,
  input  logic [pcs_pkg::DEG_W-1:0] cfg_degree_select
);

  localparam int A     = ANGLE_FRAC_BITS;
  localparam int TW    = A + 3;
  localparam int DW    = A + 2;
  localparam int XW    = 34;
  localparam int ZW    = pcs_pkg::Z_W;
  localparam int AW    = pcs_pkg::ACC_W;
  localparam int NS    = pcs_pkg::NUM_STEPS;
  localparam int DGW   = pcs_pkg::DEG_W;
  localparam int ZSHIFT = pcs_pkg::WFRAC - 2 * A;
  localparam int RSHIFT = pcs_pkg::WFRAC - RESULT_FRAC_BITS;

  localparam logic [63:0] HALF64  = pcs_pkg::pi_scaled(A - 1);
  localparam logic [63:0] PIA64   = pcs_pkg::pi_scaled(A);
  localparam logic [63:0] TWOPI64 = pcs_pkg::pi_scaled(A + 1);
  localparam logic [63:0] TPH64   = PIA64 + HALF64;
  localparam int MOD_STEPS = pcs_pkg::mod_steps(TWOPI64);

  localparam logic signed [XW-1:0] HALF_X  = XW'(HALF64);
  localparam logic [TW-1:0]        TWOPI_T = TW'(TWOPI64);
  localparam logic [TW-1:0]        HALF_T  = TW'(HALF64);
  localparam logic [TW-1:0]        TPH_T   = TW'(TPH64);
  localparam logic signed [TW:0]   PIA_S   = (TW + 1)'(PIA64);
  localparam logic signed [TW:0]   TWOPI_S = (TW + 1)'(TWOPI64);
  localparam logic [63:0]          RND_HALF = 64'd1 << (RSHIFT - 1);

  logic en;

  // Configuration.
  logic [DGW-1:0] degree_r;
  logic [DGW-1:0] degree_eff;
  logic [DGW-1:0] fit_idx;

  // Argument and its magnitude.
  logic                 v_x_r;
  logic signed [XW-1:0] x_r, x_nxt;
  logic                 v_abs_r;
  logic [31:0]          mag_r, mag_nxt;
  logic                 neg_r;

  // Modulo 2pi stages.
  logic        v_mod_r   [MOD_STEPS];
  logic [31:0] rem_r     [MOD_STEPS];
  logic        neg_mod_r [MOD_STEPS];

  // Reduced angle, folded offset, square.
  logic                 v_r1_r;
  logic [TW-1:0]        r1_r, r1_nxt;
  logic [TW-1:0]        rem_last;
  logic                 v_r2_r;
  logic signed [DW-1:0] d_r, d_nxt;
  logic                 flip_r, flip_nxt;
  logic signed [TW:0]   r_s;
  logic signed [TW:0]   d_wide;
  logic signed [2*DW-1:0] sq;
  pcs_pkg::pcs_tag_t    tag_sq_r;
  logic [ZW-1:0]        z_sq_r, z_sq_nxt;
  logic signed [AW-1:0] acc_sq_r;

  // Horner chain.
  pcs_pkg::pcs_tag_t    tag_s [NS+1];
  logic [ZW-1:0]        z_s   [NS];
  logic signed [AW-1:0] acc_s [NS+1];

  // Rounding and saturation.
  logic                 v_rd1_r;
  logic [63:0]          vmag_r, vmag_nxt;
  logic                 vneg_r;
  logic                 v_rd2_r;
  logic [31:0]          res_r, res_nxt;
  logic [63:0]          rnd;

  // Output side.
  logic        out_valid_r;
  logic [31:0] out_value_r;
  logic        skid_v_r;
  logic [31:0] skid_value_r;
  logic        out_ready;
  logic        incoming;

  // The pipeline moves unless the skid entry holds a result.
  assign en        = ~skid_v_r;
  assign in_stall  = skid_v_r;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      degree_r <= pcs_pkg::DEG_RESET;
    end else if (cfg_valid) begin
      degree_r <= cfg_degree_select;
    end
  end

  always_comb begin
    if (degree_r < pcs_pkg::DEG_MIN) begin
      degree_eff = pcs_pkg::DEG_MIN;
    end else if (degree_r > pcs_pkg::DEG_MAX) begin
      degree_eff = pcs_pkg::DEG_MAX;
    end else begin
      degree_eff = degree_r;
    end
  end

  assign fit_idx = degree_eff - DGW'(1);

  // Sine is taken as the cosine of pi/2 minus the angle.
  assign x_nxt   = in_operation ? HALF_X - XW'(in_angle) : XW'(in_angle);
  assign mag_nxt = x_r[XW-1] ? 32'(-x_r) : 32'(x_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_x_r   <= 1'b0;
      v_abs_r <= 1'b0;
    end else if (en) begin
      v_x_r   <= in_valid;
      v_abs_r <= v_x_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      x_r   <= x_nxt;
      mag_r <= mag_nxt;
      neg_r <= x_r[XW-1];
    end
  end

  for (genvar gi = 0; gi < MOD_STEPS; gi++) begin : g_mod
    localparam int SHIFT = MOD_STEPS - 1 - gi;
    localparam logic [31:0] MOD_K = 32'(TWOPI64 << SHIFT);
    logic [31:0] rem_in;
    logic        neg_in;
    logic        vld_in;
    logic [31:0] rem_nxt;

    if (gi == 0) begin : g_first
      assign rem_in = mag_r;
      assign neg_in = neg_r;
      assign vld_in = v_abs_r;
    end else begin : g_next
      assign rem_in = rem_r[gi-1];
      assign neg_in = neg_mod_r[gi-1];
      assign vld_in = v_mod_r[gi-1];
    end

    assign rem_nxt = (rem_in >= MOD_K) ? rem_in - MOD_K : rem_in;

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_mod_r[gi] <= 1'b0;
      end else if (en) begin
        v_mod_r[gi] <= vld_in;
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        rem_r[gi]     <= rem_nxt;
        neg_mod_r[gi] <= neg_in;
      end
    end
  end

  // A negative exact multiple of 2pi reduces to 2pi itself.
  assign rem_last = rem_r[MOD_STEPS-1][TW-1:0];
  assign r1_nxt   = neg_mod_r[MOD_STEPS-1] ? TWOPI_T - rem_last : rem_last;

  assign r_s = signed'({1'b0, r1_r});

  always_comb begin
    if (r1_r <= HALF_T) begin
      d_wide   = r_s;
      flip_nxt = 1'b0;
    end else if (r1_r <= TPH_T) begin
      d_wide   = r_s - PIA_S;
      flip_nxt = 1'b1;
    end else begin
      d_wide   = r_s - TWOPI_S;
      flip_nxt = 1'b0;
    end
    d_nxt = DW'(d_wide);
  end

  assign sq       = d_r * d_r;
  assign z_sq_nxt = ZW'($unsigned(sq)) << ZSHIFT;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r1_r   <= 1'b0;
      v_r2_r   <= 1'b0;
      tag_sq_r <= '0;
    end else if (en) begin
      v_r1_r         <= v_mod_r[MOD_STEPS-1];
      v_r2_r         <= v_r1_r;
      tag_sq_r.valid <= v_r2_r;
      tag_sq_r.flip  <= flip_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      r1_r     <= r1_nxt;
      d_r      <= d_nxt;
      flip_r   <= flip_nxt;
      z_sq_r   <= z_sq_nxt;
      acc_sq_r <= signed'(pcs_pkg::FIT_Q60[fit_idx]);
    end
  end

  assign tag_s[0] = tag_sq_r;
  assign z_s[0]   = z_sq_r;
  assign acc_s[0] = acc_sq_r;

  // Steps run from the highest Taylor term down; the last one closes 1 - z*acc.
  for (genvar gs = 0; gs < NS; gs++) begin : g_step
    if (gs < NS - 1) begin : g_mid
      pcs_horner_step #(
        .STEP (NS - 1 - gs)
      ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .degree_i (degree_eff),
        .tag_i    (tag_s[gs]),
        .z_i      (z_s[gs]),
        .acc_i    (acc_s[gs]),
        .tag_o    (tag_s[gs+1]),
        .z_o      (z_s[gs+1]),
        .acc_o    (acc_s[gs+1])
      );
    end else begin : g_last
      pcs_horner_step #(
        .STEP (0)
      ) u_step (
        .clk      (clk),
        .rst_n    (rst_n),
        .en       (en),
        .degree_i (degree_eff),
        .tag_i    (tag_s[gs]),
        .z_i      (z_s[gs]),
        .acc_i    (acc_s[gs]),
        .tag_o    (tag_s[gs+1]),
        .z_o      (),
        .acc_o    (acc_s[gs+1])
      );
    end
  end

  assign vmag_nxt = acc_s[NS][AW-1] ? unsigned'(-acc_s[NS]) : unsigned'(acc_s[NS]);
  assign rnd      = (vmag_r + RND_HALF) >> RSHIFT;

  // Round the magnitude, ties away from zero, then saturate.
  always_comb begin
    if (!vneg_r) begin
      if (rnd > 64'h0000_0000_7FFF_FFFF) res_nxt = 32'h7FFF_FFFF;
      else res_nxt = rnd[31:0];
    end else begin
      if (rnd > 64'h0000_0000_8000_0000) res_nxt = 32'h8000_0000;
      else res_nxt = -rnd[31:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_rd1_r <= 1'b0;
      v_rd2_r <= 1'b0;
    end else if (en) begin
      v_rd1_r <= tag_s[NS].valid;
      v_rd2_r <= v_rd1_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      vmag_r <= vmag_nxt;
      vneg_r <= acc_s[NS][AW-1];
      res_r  <= res_nxt;
    end
  end

  // A result leaves the pipeline whenever it advances; a stalled output
  // parks it in the skid entry.
  assign incoming  = en & v_rd2_r;
  assign out_ready = ~out_valid_r | ~out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      skid_v_r    <= 1'b0;
    end else if (out_ready) begin
      if (skid_v_r) begin
        out_valid_r <= 1'b1;
        skid_v_r    <= 1'b0;
      end else begin
        out_valid_r <= incoming;
      end
    end else if (incoming) begin
      skid_v_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready) begin
      out_value_r <= skid_v_r ? skid_value_r : res_r;
    end
    if (!out_ready && incoming) begin
      skid_value_r <= res_r;
    end
  end

  assign out_valid = out_valid_r;
  assign out_value = signed'(out_value_r);

endmodule

/* dv/poly_cosine_sine_approx_tb.sv */
// ----------------------------------------------------------------------------
// poly_cosine_sine_approx_tb: self-checking bench for the cosine/sine block
// Streams directed and random angles through the block under every degree
// setting. A scoreboard predicts each Q2.30 result in 64-bit fixed point and
// compares it with the block output in order. Both channels idle at random.
// ----------------------------------------------------------------------------

class trig_scoreboard;
  logic signed [31:0] expected_values[$];
  int unsigned mismatches;
  logic [2:0] order;
  longint half_pi;
  longint pi_a;
  longint two_pi;
  longint three_half_pi;
  logic [5:0][63:0] fit_q60;
  logic [4:0][63:0] taylor_q60;

  function new();
    logic [5:0][63:0] fit_num;
    logic [4:0][63:0] fact;
    fit_num = {64'd20596614152, 64'd2704911813978, 64'd241341770629924,
               64'd13293401938494940, 64'd383866512097261799,
               64'd4052847345693510858};
    fact = {64'd3628800, 64'd40320, 64'd720, 64'd24, 64'd2};
    half_pi = scaled_pi(pcs_pkg::ANGLE_FRAC_BITS - 1);
    pi_a = scaled_pi(pcs_pkg::ANGLE_FRAC_BITS);
    two_pi = scaled_pi(pcs_pkg::ANGLE_FRAC_BITS + 1);
    three_half_pi = pi_a + half_pi;
    for (int k = 0; k < 6; k++) fit_q60[k] = ratio_q60(fit_num[k], 64'd10000000000000000000);
    for (int k = 0; k < 5; k++) taylor_q60[k] = ratio_q60(64'd1, fact[k]);
    order = 3'd6;
    mismatches = 0;
  endfunction

  function longint scaled_pi(int e);
    logic [64:0] sum;
    sum = {1'b0, 64'hC90F_DAA2_2168_C235} + (65'd1 << (61 - e));
    return longint'(sum >> (62 - e));
  endfunction

  // num/den in Q60, rounded half up.
  function logic [63:0] ratio_q60(logic [63:0] num, logic [63:0] den);
    logic [127:0] q;
    q = ({64'b0, num} << 61) / {64'b0, den};
    q = (q + 128'd1) >> 1;
    return q[63:0];
  endfunction

  // Q60 product, rounded to nearest with ties away from zero.
  function longint mul_q60(longint a, longint b);
    logic [63:0] ua;
    logic [63:0] ub;
    logic [127:0] prod;
    ua = a;
    ub = b;
    if (a < 0) ua = -ua;
    if (b < 0) ub = -ub;
    prod = ({64'b0, ua} * {64'b0, ub} + (128'd1 << 59)) >> 60;
    return ((a < 0) != (b < 0)) ? -longint'(prod[63:0]) : longint'(prod[63:0]);
  endfunction

  function logic signed [31:0] approx_trig(bit op, logic signed [31:0] ang);
    longint x;
    longint r;
    longint d;
    longint z;
    longint acc;
    longint p;
    longint v;
    longint res;
    logic [63:0] mag;
    bit flip;
    int n;
    x = op ? half_pi - longint'(ang) : longint'(ang);
    // A negative exact multiple of 2pi lands on 2pi, not on zero.
    if (x > 0) r = x % two_pi;
    else if (x < 0) r = two_pi - ((-x) % two_pi);
    else r = 0;
    flip = 1'b0;
    if (r <= half_pi) d = r;
    else if (r <= three_half_pi) begin
      d = r - pi_a;
      flip = 1'b1;
    end else d = r - two_pi;
    z = (d * d) << (60 - 2 * pcs_pkg::ANGLE_FRAC_BITS);
    n = order;
    if (n < 1) n = 1;
    if (n > 6) n = 6;
    acc = longint'(fit_q60[n-1]);
    for (int k = n - 1; k >= 1; k--) acc = longint'(taylor_q60[k-1]) - mul_q60(z, acc);
    p = mul_q60(z, acc);
    v = flip ? p - (longint'(1) << 60) : (longint'(1) << 60) - p;
    mag = v;
    if (v < 0) mag = -mag;
    mag = (mag + (64'd1 << (59 - pcs_pkg::RESULT_FRAC_BITS)))
          >> (60 - pcs_pkg::RESULT_FRAC_BITS);
    res = (v < 0) ? -longint'(mag) : longint'(mag);
    if (res > longint'(32'sh7FFF_FFFF)) res = longint'(32'sh7FFF_FFFF);
    if (res < longint'(32'sh8000_0000)) res = longint'(32'sh8000_0000);
    return 32'(res);
  endfunction

  function void set_order(logic [2:0] n);
    order = n;
  endfunction

  function void note_angle(bit op, logic signed [31:0] ang);
    expected_values.push_back(approx_trig(op, ang));
  endfunction

  function int pending();
    return expected_values.size();
  endfunction

  function void check_value(logic signed [31:0] got);
    logic signed [31:0] want;
    if (expected_values.size() == 0) begin
      $display("%0t: unexpected out_value transfer: expected none, actual %0d", $time, got);
      mismatches++;
    end else begin
      want = expected_values.pop_front();
      if (got !== want) begin
        $display("%0t: out_value mismatch: expected %0d, actual %0d", $time, want, got);
        mismatches++;
      end
    end
  endfunction
endclass

module poly_cosine_sine_approx_tb;

  localparam int QUIET_LIMIT = 3000;
  localparam int DRAIN_CYCLES = 48;
  localparam int PHASE_ITEMS = 63;
  localparam int IDLE_PCT = 27;
  // Degree settings in run order; index 0 is applied first.
  localparam logic [7:0][2:0] DEGREE_PLAN = {3'd5, 3'd4, 3'd6, 3'd2, 3'd3, 3'd7, 3'd0, 3'd1};
  localparam int CALM_PHASE = 5;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic in_operation = 1'b0;
  logic signed [31:0] in_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [31:0] out_value;
  logic cfg_valid = 1'b0;
  logic cfg_ready;
  logic [pcs_pkg::DEG_W-1:0] cfg_degree_select = pcs_pkg::DEG_RESET;

  bit calm = 1'b0;
  int unsigned quiet_cycles = 0;
  trig_scoreboard book;

  poly_cosine_sine_approx uut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_operation      (in_operation),
    .in_angle          (in_angle),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_value         (out_value),
    .cfg_valid         (cfg_valid),
    .cfg_ready         (cfg_ready),
    .cfg_degree_select (cfg_degree_select)
  );

  always #2 clk = ~clk;

  // Picks the input angle so that the folded argument equals target.
  function automatic logic signed [31:0] aim_angle(bit op, longint target);
    return op ? 32'(book.half_pi - target) : 32'(target);
  endfunction

  task automatic send_item(bit op, logic signed [31:0] ang);
    while (!calm && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_operation <= op;
    in_angle <= ang;
    do @(posedge clk); while (in_stall);
    book.note_angle(op, ang);
  endtask

  task automatic write_degree(logic [2:0] n);
    cfg_valid <= 1'b1;
    cfg_degree_select <= n;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    book.set_order(n);
  endtask

  task automatic run_directed();
    longint hp;
    longint pa;
    longint tp;
    longint tph;
    hp = book.half_pi;
    pa = book.pi_a;
    tp = book.two_pi;
    tph = book.three_half_pi;
    send_item(1'b0, 32'sd0);
    send_item(1'b1, 32'sd0);
    send_item(1'b0, 32'sh7FFF_FFFF);
    send_item(1'b0, 32'sh8000_0000);
    send_item(1'b1, 32'sh7FFF_FFFF);
    send_item(1'b1, 32'sh8000_0000);
    send_item(1'b0, 32'sd1);
    send_item(1'b0, -32'sd1);
    // Region boundaries and exact multiples of the 2pi constant.
    send_item(1'b0, aim_angle(1'b0, hp));
    send_item(1'b0, aim_angle(1'b0, hp + 1));
    send_item(1'b0, aim_angle(1'b0, pa));
    send_item(1'b0, aim_angle(1'b0, tph));
    send_item(1'b0, aim_angle(1'b0, tph + 1));
    send_item(1'b0, aim_angle(1'b0, tp));
    send_item(1'b0, aim_angle(1'b0, tp - 1));
    send_item(1'b0, aim_angle(1'b0, -tp));
    send_item(1'b0, aim_angle(1'b0, -2 * tp));
    send_item(1'b1, aim_angle(1'b1, 0));
    send_item(1'b1, aim_angle(1'b1, -tp));
    send_item(1'b1, aim_angle(1'b1, hp));
    send_item(1'b1, aim_angle(1'b1, pa));
    send_item(1'b1, aim_angle(1'b1, tph + 1));
  endtask

  task automatic run_random(int count);
    bit op;
    longint target;
    longint edge_pt;
    int j;
    repeat (count) begin
      op = $urandom_range(1);
      case ($urandom_range(9))
        0, 1, 2, 3: send_item(op, $urandom());
        4, 5: send_item(op, $signed($urandom()) >>> 3);
        default: begin
          j = $urandom_range(38);
          case ($urandom_range(3))
            0: edge_pt = 0;
            1: edge_pt = book.half_pi;
            2: edge_pt = book.pi_a;
            default: edge_pt = book.three_half_pi;
          endcase
          target = longint'(j - 19) * book.two_pi + edge_pt + longint'(int'($urandom_range(8)) - 4);
          send_item(op, aim_angle(op, target));
        end
      endcase
    end
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) book.check_value(out_value);
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  // Any cycle without a transfer on any channel counts toward the timeout.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    book = new();
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    run_directed();
    for (int phase = 0; phase < 8; phase++) begin
      in_valid <= 1'b0;
      while (book.pending() != 0) @(posedge clk);
      write_degree(DEGREE_PLAN[phase]);
      calm = (phase == CALM_PHASE);
      run_random(PHASE_ITEMS);
    end
    in_valid <= 1'b0;
    calm = 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (book.mismatches == 0) $display("DONE: 0 errors");
    else $display("DONE: errors detected");
    $finish;
  end

endmodule

/* filelist.f */
hw/rtl/pcs_pkg.sv
hw/rtl/pcs_horner_step.sv
hw/rtl/poly_cosine_sine_approx.sv
dv/poly_cosine_sine_approx_tb.sv
